/* design/aes_pkg.sv */
// aes_pkg: shared types, constants and functions for the aes-128 block cipher
// depends on nothing; used by aes_round and aes128_block_cipher
`timescale 1ns / 1ps
package aes_pkg;

    localparam int NumRounds = 10;
    localparam int KeyWidth  = 128;
    localparam int CfgIdxW   = 1;

    typedef enum logic [0:0] {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KEY_HI = 1'b0,
        REG_KEY_LO = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic        cmd;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } in_word_t;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } out_word_t;

    // what travels alongside the state from stage to stage
    typedef struct packed {
        logic valid;
        logic cmd;
    } stage_ctl_t;

    function automatic logic [7:0] sbox_fwd(input logic [7:0] x);
        logic [7:0] r;
        case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sbox_inv(input logic [7:0] x);
        logic [7:0] r;
        case (x)
            8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
            8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
            8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
            8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
            8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
            8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
            8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
            8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
            8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
            8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
            8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
            8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
            8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
            8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
            8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
            8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
            8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
            8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
            8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
            8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
            8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
            8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
            8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
            8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
            8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
            8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
            8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
            8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
            8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
            8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
            8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
            8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
            8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
            8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
            8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
            8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
            8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
            8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
            8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
            8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
            8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
            8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
            8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
            8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
            8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
            8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
            8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
            8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
            8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
            8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
            8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
            8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
            8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
            8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
            8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
            8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
            8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
            8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
            8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
            8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
            8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
            8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
            8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
            8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1:  v = 8'h01;
            4'd2:  v = 8'h02;
            4'd3:  v = 8'h04;
            4'd4:  v = 8'h08;
            4'd5:  v = 8'h10;
            4'd6:  v = 8'h20;
            4'd7:  v = 8'h40;
            4'd8:  v = 8'h80;
            4'd9:  v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    // next round key from the previous one
    function automatic logic [127:0] next_key(input logic [127:0] k,
                                              input logic [3:0] r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {sbox_fwd(w3[23:16]) ^ rcon(r), sbox_fwd(w3[15:8]),
             sbox_fwd(w3[7:0]), sbox_fwd(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // previous round key from the next one
    function automatic logic [127:0] prev_key(input logic [127:0] k,
                                              input logic [3:0] r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        w3 = w3 ^ w2;
        w2 = w2 ^ w1;
        w1 = w1 ^ w0;
        t = {sbox_fwd(w3[23:16]) ^ rcon(r), sbox_fwd(w3[15:8]),
             sbox_fwd(w3[7:0]), sbox_fwd(w3[31:24])};
        w0 = w0 ^ t;
        return {w0, w1, w2, w3};
    endfunction

endpackage

/* design/aes128_block_cipher.sv */
// aes128_block_cipher: aes-128 ecb encrypt and decrypt, fully unrolled round pipeline
// depends on aes_pkg and aes_round
`timescale 1ns / 1ps
// A 128-bit block is taken on a cycle where start is high and busy is low; in normal
// running busy stays low, so a word may enter every cycle. The result appears on result
// with done high for one cycle, once the word has passed through one stage for the
// initial key add and one registered stage for each of the ten rounds. Round keys for
// both directions are expanded one round per cycle down a register chain, so busy is
// high after reset and after every key write while the chain settles. Write the key only
// while no word is in flight.
module aes128_block_cipher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  aes_pkg::in_word_t   operand,
    output logic                done,
    output aes_pkg::out_word_t  result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [aes_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [63:0]         cfg_data
);

    localparam int N = aes_pkg::NumRounds;
    localparam int SettleCycles = N + 1;

    logic [63:0]  key_hi_reg, key_lo_reg;
    // rk_reg[r] is round key r, expanded one round per cycle down the chain
    logic [127:0] rk_reg [N+1];
    logic [127:0] rk_next [N+1];
    logic [3:0]   settle_reg, settle_next;
    aes_pkg::stage_ctl_t ctl0_reg;
    logic [127:0] s0_reg;
    aes_pkg::stage_ctl_t ctl [N+1];
    logic [127:0] st [N+1];

    assign busy      = (settle_reg != 4'd0);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == aes_pkg::REG_KEY_HI)
            begin
                key_hi_reg <= cfg_data;
            end
            if (cfg_index == aes_pkg::REG_KEY_LO)
            begin
                key_lo_reg <= cfg_data;
            end
        end
    end

    // words are held off until a new key has run down the whole chain
    always_comb
    begin
        if (cfg_valid && cfg_ready)
        begin
            settle_next = 4'(SettleCycles);
        end
        else if (settle_reg != 4'd0)
        begin
            settle_next = settle_reg - 4'd1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= 4'(SettleCycles);
        end
        else
        begin
            settle_reg <= settle_next;
        end
    end

    always_comb
    begin
        rk_next[0] = {key_hi_reg, key_lo_reg};
        for (int r = 1; r <= N; r++)
        begin
            rk_next[r] = aes_pkg::next_key(rk_reg[r-1], 4'(r));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r <= N; r++)
            begin
                rk_reg[r] <= '0;
            end
        end
        else
        begin
            for (int r = 0; r <= N; r++)
            begin
                rk_reg[r] <= rk_next[r];
            end
        end
    end

    // stage 0: initial key add with key 0 or key 10
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else
        begin
            ctl0_reg.valid <= start && !busy;
            ctl0_reg.cmd   <= operand.cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= {operand.block_hi, operand.block_lo}
                  ^ ((operand.cmd == aes_pkg::CMD_DECRYPT) ? rk_reg[N] : rk_reg[0]);
    end

    assign ctl[0] = ctl0_reg;
    assign st[0]  = s0_reg;

    for (genvar g = 1; g <= N; g++)
    begin : g_round
        aes_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (1'b1),
            .last      (g == N),
            .ctl_in    (ctl[g-1]),
            .state_in  (st[g-1]),
            .key_enc   (rk_reg[g]),
            .key_dec   (rk_reg[N-g]),
            .ctl_out   (ctl[g]),
            .state_out (st[g])
        );
    end

    assign done             = ctl[N].valid;
    assign result.result_hi = st[N][127:64];
    assign result.result_lo = st[N][63:0];

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctl[N].valid == $past(ctl[N-1].valid))
        else $error("done does not follow the pipeline");
    a_busy_after_key: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> busy)
        else $error("busy not raised after a key write");
    a_stage0_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start && !busy) |-> ctl[0].valid)
        else $error("accepted word lost");
    a_cmd_carried: assert property (@(posedge clk) disable iff (!rst_n)
        ctl[1].valid |-> ctl[1].cmd == $past(ctl[0].cmd))
        else $error("cmd not carried with the word");
`endif

endmodule

/* design/aes_round.sv */
// aes_round: one registered cipher round, forward or inverse by the word's cmd
// depends on aes_pkg
`timescale 1ns / 1ps
module aes_round (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               last,
    input  aes_pkg::stage_ctl_t ctl_in,
    input  logic [127:0]       state_in,
    input  logic [127:0]       key_enc,
    input  logic [127:0]       key_dec,
    output aes_pkg::stage_ctl_t ctl_out,
    output logic [127:0]       state_out
);

    aes_pkg::stage_ctl_t ctl_reg;
    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic [127:0] fwd_sr, inv_sr, fwd_mc, inv_mc, fwd_res, inv_res;

    always_comb
    begin
        logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3, b4, b5, b6, b7;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                fwd_sr[127 - 8*(4*c + r) -: 8] =
                    aes_pkg::sbox_fwd(aes_pkg::get_byte(state_in, r + 4*((c + r) % 4)));
                inv_sr[127 - 8*(4*c + r) -: 8] =
                    aes_pkg::sbox_inv(aes_pkg::get_byte(state_in, r + 4*((c + 4 - r) % 4)));
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = aes_pkg::get_byte(fwd_sr, 4*c);
            a1 = aes_pkg::get_byte(fwd_sr, 4*c + 1);
            a2 = aes_pkg::get_byte(fwd_sr, 4*c + 2);
            a3 = aes_pkg::get_byte(fwd_sr, 4*c + 3);
            fwd_mc[127 - 32*c -: 32] = {
                aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3,
                aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3)};
        end
        // inverse: add round key first, then inverse mix
        inv_res = inv_sr ^ key_dec;
        for (int c = 0; c < 4; c++)
        begin
            a0 = aes_pkg::get_byte(inv_res, 4*c);
            a1 = aes_pkg::get_byte(inv_res, 4*c + 1);
            a2 = aes_pkg::get_byte(inv_res, 4*c + 2);
            a3 = aes_pkg::get_byte(inv_res, 4*c + 3);
            // x*2, x*4, x*8 of a0 and a1, x*2 and x*4 of a2
            b0 = aes_pkg::xtime(a0); b1 = aes_pkg::xtime(b0); b2 = aes_pkg::xtime(b1);
            b3 = aes_pkg::xtime(a1); b4 = aes_pkg::xtime(b3); b5 = aes_pkg::xtime(b4);
            b6 = aes_pkg::xtime(a2); b7 = aes_pkg::xtime(b6);
            inv_mc[127 - 32*c -: 32] = {
                (b2^b1^b0) ^ (b5^b3^a1) ^ (aes_pkg::xtime(b7)^b7^a2)
                    ^ (aes_pkg::xtime(aes_pkg::xtime(aes_pkg::xtime(a3)))^a3),
                (b2^a0) ^ (b5^b4^b3) ^ (aes_pkg::xtime(b7)^b6^a2)
                    ^ (aes_pkg::xtime(aes_pkg::xtime(aes_pkg::xtime(a3)))
                       ^ aes_pkg::xtime(aes_pkg::xtime(a3))^a3),
                (b2^b1^a0) ^ (b5^a1) ^ (aes_pkg::xtime(b7)^b7^b6)
                    ^ (aes_pkg::xtime(aes_pkg::xtime(aes_pkg::xtime(a3)))
                       ^ aes_pkg::xtime(a3)^a3),
                (b2^b0^a0) ^ (b5^b4^a1) ^ (aes_pkg::xtime(b7)^a2)
                    ^ (aes_pkg::xtime(aes_pkg::xtime(aes_pkg::xtime(a3)))
                       ^ aes_pkg::xtime(aes_pkg::xtime(a3))^aes_pkg::xtime(a3))};
        end
        fwd_res = (last ? fwd_sr : fwd_mc) ^ key_enc;
        state_next = (ctl_in.cmd == aes_pkg::CMD_DECRYPT) ? (last ? inv_res : inv_mc)
                                                          : fwd_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign state_out = state_reg;

endmodule
